/* rtl/sfd_pkg.sv */
// sfd_pkg: shared constants for the serial bus frame decoder.
// Stands alone; used by sbus_frame_decoder.
`timescale 1ns / 1ps

package sfd_pkg;

  // Frame layout
  localparam logic [7:0]  SYNC_BYTE     = 8'h0F;
  localparam logic [4:0]  LAST_POS      = 5'd24;  // end byte position
  localparam logic [4:0]  FLAGS_POS     = 5'd23;  // flags byte position
  localparam int unsigned DATA_BYTES    = 23;     // stored bytes 1..23
  localparam int unsigned DATA_W        = DATA_BYTES * 8;
  localparam int unsigned FIELD_W       = 11;

  // Channel numbering
  localparam logic [4:0]  LAST_CHANNEL  = 5'd17;
  localparam int unsigned CHANNEL_W     = 5;
  localparam int unsigned VALUE_W       = 12;

  // Digital channel levels
  localparam logic [11:0] DIGITAL_HIGH  = 12'd2000;
  localparam logic [11:0] DIGITAL_LOW   = 12'd1000;

  // Register reset
  localparam logic [10:0] MID_OFFSET_RST = 11'd988;

  // Flags byte bit positions
  localparam int unsigned FAILSAFE_BIT  = 3;

endpackage

/* rtl/sbus_frame_decoder.sv */
// The accepted end byte loads the snapshot and starts the emitter; the output register
// then takes one channel result per cycle unless the output stalls. Bytes are taken one
// per cycle; the end byte is held off only while the emitter is still busy with the
// previous frame's 18 results. A snapshot copy lets the next frame collect meanwhile.
// Reset: asynchronous, active low; clears position, emitter and output valid, and sets
// mid_offset to 988. Frame and snapshot bytes are not reset.
//
// sbus_frame_decoder: gathers 25-byte frames and emits 18 channel results.
// Depends on sfd_pkg.
`timescale 1ns / 1ps

module sbus_frame_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [10:0] cfg_data_i,
  // byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  // channel results
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  channel_o,
  output logic [11:0] value_o,
  output logic        signal_ok_o,
  output logic        last_o
);

  logic [10:0]                   mid_q;
  logic [4:0]                    pos_q;
  logic [sfd_pkg::DATA_W-1:0]    store_q;
  logic [sfd_pkg::DATA_W-1:0]    snap_q;
  logic                          busy_q;
  logic [4:0]                    ch_q;
  logic                          out_valid_q;
  logic [4:0]                    channel_q;
  logic [11:0]                   value_q;
  logic                          signal_ok_q;
  logic                          last_q;

  logic                          in_acc;
  logic                          drop;
  logic                          frame_end;
  logic                          load;
  logic [7:0]                    field_lsb;
  logic [sfd_pkg::FIELD_W-1:0]   field;
  logic [7:0]                    flags;
  logic [11:0]                   value_d;

  // Register port never blocks
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q <= sfd_pkg::MID_OFFSET_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mid_q <= cfg_data_i;
    end
  end

  // Hold the end byte while the previous frame still drains
  assign in_stall_o = (pos_q == sfd_pkg::LAST_POS) && busy_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign drop       = (pos_q == 5'd0) && (rx_byte_i != sfd_pkg::SYNC_BYTE);
  assign frame_end  = in_acc && (pos_q == sfd_pkg::LAST_POS);

  // Advance the frame position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 5'd0;
    end else if (in_acc && !drop) begin
      pos_q <= frame_end ? 5'd0 : pos_q + 5'd1;
    end
  end

  // Store data bytes 1..23; the sync byte itself is not needed
  always_ff @(posedge clk_i) begin
    if (in_acc && (pos_q != 5'd0) && (pos_q != sfd_pkg::LAST_POS)) begin
      store_q[(8'(pos_q) - 8'd1) * 8'd8 +: 8] <= rx_byte_i;
    end
  end

  // Snapshot the frame on its end byte
  always_ff @(posedge clk_i) begin
    if (frame_end) begin
      snap_q <= store_q;
    end
  end

  // Emitter: one channel per cycle when the output register is free
  assign load = busy_q && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ch_q   <= 5'd0;
    end else if (frame_end) begin
      busy_q <= 1'b1;
      ch_q   <= 5'd0;
    end else if (load) begin
      busy_q <= (ch_q != sfd_pkg::LAST_CHANNEL);
      ch_q   <= ch_q + 5'd1;
    end
  end

  // Pick the 11-bit field, or the flags bit for channels 16 and 17, and form the channel value
  assign field_lsb = 8'(ch_q[3:0]) * 8'd11;
  assign field     = snap_q[field_lsb +: sfd_pkg::FIELD_W];
  assign flags     = snap_q[sfd_pkg::DATA_W-1 -: 8];

  always_comb begin
    if (ch_q[4]) begin
      value_d = flags[ch_q[0]] ? sfd_pkg::DIGITAL_HIGH : sfd_pkg::DIGITAL_LOW;
    end else begin
      value_d = 12'(field[sfd_pkg::FIELD_W-1:1]) + 12'(mid_q);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      channel_q   <= ch_q;
      value_q     <= value_d;
      signal_ok_q <= !flags[sfd_pkg::FAILSAFE_BIT];
      last_q      <= (ch_q == sfd_pkg::LAST_CHANNEL);
    end
  end

  assign out_valid_o = out_valid_q;
  assign channel_o   = channel_q;
  assign value_o     = value_q;
  assign signal_ok_o = signal_ok_q;
  assign last_o      = last_q;

  // Checks
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= sfd_pkg::LAST_POS)
    else $error("frame position out of range");

  a_ch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> ch_q <= sfd_pkg::LAST_CHANNEL)
    else $error("channel counter out of range while busy");

  a_start_ch0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> ch_q == 5'd0)
    else $error("emission did not start at channel 0");

  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && ch_q == sfd_pkg::LAST_CHANNEL) |=> !busy_q)
    else $error("emitter still busy after last channel");

  a_last_ch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && last_q) |-> channel_q == sfd_pkg::LAST_CHANNEL)
    else $error("last flag on wrong channel");

endmodule

/* tb/tb_top.sv */
// tb_top: self-checking bench for sbus_frame_decoder. Drives byte and offset requests,
// predicts the 18 channel results of each frame and checks every result field by field.
// Depends on sfd_pkg and sbus_frame_decoder.
`timescale 1ns / 1ps

module tb_top;

  localparam int CLK_PERIOD  = 10;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 25;
  localparam int MAX_REPORTS = 20;

  typedef struct packed {
    logic [sfd_pkg::CHANNEL_W-1:0] channel;
    logic [sfd_pkg::VALUE_W-1:0]   value;
    logic                          signal_ok;
    logic                          is_last;
  } chan_result_t;

  typedef enum {FRAME_WHOLE, FRAME_NOISY, FRAME_CUT} frame_kind_e;

  // Predict channel results from accepted bytes and check what the block emits
  class frame_tracker;
    logic [10:0]  mid_offset;
    logic [4:0]   position;
    logic [7:0]   frame_bytes [24];
    chan_result_t expected_channels [$];
    int           mismatches;

    function new();
      mid_offset = sfd_pkg::MID_OFFSET_RST;
      position   = '0;
      mismatches = 0;
    endfunction

    function void set_offset(logic [10:0] v);
      mid_offset = v;
    endfunction

    function int pending();
      return expected_channels.size();
    endfunction

    function void take_byte(logic [7:0] b);
      logic [sfd_pkg::DATA_W-1:0]  payload;
      logic [sfd_pkg::FIELD_W-1:0] field;
      logic [7:0]                  flags;
      chan_result_t                r;
      // drop anything but sync while between frames
      if (position == 5'd0 && b != sfd_pkg::SYNC_BYTE) return;
      if (position < sfd_pkg::LAST_POS) begin
        frame_bytes[position] = b;
        position = position + 5'd1;
        return;
      end
      // end byte: emit the whole frame
      position = '0;
      for (int i = 1; i <= sfd_pkg::DATA_BYTES; i++) payload[8*(i-1) +: 8] = frame_bytes[i];
      flags = frame_bytes[sfd_pkg::FLAGS_POS];
      for (int ch = 0; ch <= sfd_pkg::LAST_CHANNEL; ch++) begin
        r.channel   = sfd_pkg::CHANNEL_W'(ch);
        r.signal_ok = ~flags[sfd_pkg::FAILSAFE_BIT];
        r.is_last   = (ch == sfd_pkg::LAST_CHANNEL);
        if (ch < 16) begin
          field   = payload[sfd_pkg::FIELD_W*ch +: sfd_pkg::FIELD_W];
          r.value = sfd_pkg::VALUE_W'(field[sfd_pkg::FIELD_W-1:1]) +
                    sfd_pkg::VALUE_W'(mid_offset);
        end else begin
          r.value = flags[ch-16] ? sfd_pkg::DIGITAL_HIGH : sfd_pkg::DIGITAL_LOW;
        end
        expected_channels.push_back(r);
      end
    endfunction

    task report(string what, int got, int want);
      if (mismatches < MAX_REPORTS)
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
    endtask

    task check_channel(logic [4:0] channel, logic [11:0] value, logic ok, logic is_last);
      chan_result_t want;
      if (expected_channels.size() == 0) begin
        report("unexpected result, channel", channel, -1);
        return;
      end
      want = expected_channels.pop_front();
      if (channel !== want.channel)   report("channel", channel, want.channel);
      if (value !== want.value)       report("value", value, want.value);
      if (ok !== want.signal_ok)      report("signal_ok", ok, want.signal_ok);
      if (is_last !== want.is_last)   report("last", is_last, want.is_last);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [10:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic [7:0]  rx_byte = '0;
  logic        out_stall = 1'b0;
  logic        cfg_ready, in_stall, out_valid, signal_ok, last_flag;
  logic [4:0]  channel;
  logic [11:0] value;

  frame_tracker tracker;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int stall_left = 0;
  int stall_gap;
  int cycle_count = 0;

  sbus_frame_decoder dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .rx_byte_i   (rx_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .channel_o   (channel),
    .value_o     (value),
    .signal_ok_o (signal_ok),
    .last_o      (last_flag)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Result side: random stalls, plus a long hold-off when asked for
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      stall_left  = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      stall_gap = pick_gap(out_idle_pct);
      out_stall <= (stall_gap > 0);
      if (stall_gap > 0) stall_left = stall_gap - 1;
    end
  end

  always @(posedge clk) begin
    if (rst_ni && out_valid && !out_stall)
      tracker.check_channel(channel, value, signal_ok, last_flag);
  end

  // Offer one byte request and hold it until taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap(in_idle_pct);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    tracker.take_byte(b);
  endtask

  task automatic send_frame(input frame_kind_e kind);
    int cut;
    if (kind == FRAME_NOISY) repeat ($urandom_range(1, 4)) send_byte(rand_byte());
    if (kind == FRAME_CUT) begin
      // truncated frame: the next sync byte ends up as data
      cut = $urandom_range(2, 20);
      send_byte(sfd_pkg::SYNC_BYTE);
      repeat (cut) send_byte(rand_byte());
    end
    send_byte(sfd_pkg::SYNC_BYTE);
    repeat (22) send_byte(rand_byte());
    send_byte(8'($urandom));
    send_byte(8'($urandom));
  endtask

  task automatic run_phase(input int frames);
    int r;
    repeat (frames) begin
      r = $urandom_range(0, 9);
      send_frame(r < 7 ? FRAME_WHOLE : (r < 9 ? FRAME_NOISY : FRAME_CUT));
    end
  endtask

  // Stop offering, drain every pending result and let the block settle
  task automatic go_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_offset(input logic [10:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_offset(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    tracker = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    // Directed: idle noise, then one frame of extremes at the reset offset
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h0E);
    send_byte(sfd_pkg::SYNC_BYTE);
    for (int i = 1; i <= 22; i++)
      send_byte(i <= 11 ? 8'hFF : (i == 15 ? sfd_pkg::SYNC_BYTE : 8'h00));
    send_byte(8'h07);   // both digital bits and frame-lost set, failsafe clear
    send_byte(8'hA5);   // end byte is not checked
    go_quiet();

    // Lowest offset with moderate idling
    write_offset(11'd0);
    in_idle_pct  = 30;
    out_idle_pct = 30;
    run_phase(2);
    go_quiet();

    // Highest offset; hold results off so the end byte backs up
    write_offset(11'h7FF);
    in_idle_pct  = 10;
    out_idle_pct = 20;
    hold_requests++;
    send_frame(FRAME_WHOLE);
    send_frame(FRAME_WHOLE);
    go_quiet();
    run_phase(1);
    go_quiet();

    // Random offsets; heavier idling on both sides, then mostly on the result side
    write_offset(11'($urandom));
    in_idle_pct  = 50;
    out_idle_pct = 50;
    run_phase(2);
    go_quiet();

    write_offset(11'($urandom));
    in_idle_pct  = 10;
    out_idle_pct = 60;
    run_phase(2);
    go_quiet();

    if (tracker.mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
